### rtl/mlpsgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsgd_pkg
// Shared sizes, codes, datapath command type and saturation helpers for the
// perceptron trainer.
// ----------------------------------------------------------------------------
package mlpsgd_pkg;

  localparam int NUM_INPUTS  = 4;
  localparam int NUM_HIDDEN  = 2;
  localparam int NUM_OUTPUTS = 2;

  localparam int OFS_W1      = 0;
  localparam int OFS_B1      = NUM_HIDDEN * NUM_INPUTS;
  localparam int OFS_W2      = OFS_B1 + NUM_HIDDEN;
  localparam int OFS_B2      = OFS_W2 + NUM_OUTPUTS * NUM_HIDDEN;
  localparam int NUM_WEIGHTS = OFS_B2 + NUM_OUTPUTS;

  localparam int WIX_W  = $clog2(NUM_WEIGHTS);
  localparam int CTR_W  = $clog2(NUM_WEIGHTS) + 1;
  localparam int SEL_W  = 4;
  localparam int XI_W   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int HI_W   = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
  localparam int OI_W   = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

  localparam int DATA_W = 32;
  localparam int ACC_W  = 48;
  localparam int SUM_W  = 52;
  localparam int OPR_W  = 33;
  localparam int PROD_W = 66;
  localparam int USUM_W = 58;
  localparam int UPD_W  = 82;
  localparam int CNT_W  = 6;
  localparam int BS_W   = 7;

  localparam logic [BS_W-1:0]   BATCH_RST = 7'd10;
  localparam logic [BS_W-1:0]   BATCH_MAX = 7'd64;
  localparam logic [31:0]       STEP_RST  = 32'd429497;
  localparam logic [23:0]       LEAK_RST  = 24'd1678;
  localparam logic [24:0]       ONE_Q24   = 25'h100_0000;

  // request kinds
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_INFER = 2'd1;
  localparam logic [1:0] REQ_TRAIN = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_BATCH = 2'd0;
  localparam logic [1:0] CFG_STEP  = 2'd1;
  localparam logic [1:0] CFG_LEAK  = 2'd2;

  // multiplier operand selections
  localparam logic [3:0] M_NONE  = 4'd0;
  localparam logic [3:0] M_WX    = 4'd1;
  localparam logic [3:0] M_WH    = 4'd2;
  localparam logic [3:0] M_ACT_H = 4'd3;
  localparam logic [3:0] M_ACT_Y = 4'd4;
  localparam logic [3:0] M_ERR   = 4'd5;
  localparam logic [3:0] M_WE    = 4'd6;
  localparam logic [3:0] M_BACKD = 4'd7;
  localparam logic [3:0] M_EH    = 4'd8;
  localparam logic [3:0] M_GX    = 4'd9;
  localparam logic [3:0] M_UHI   = 4'd10;
  localparam logic [3:0] M_ULO   = 4'd11;
  localparam logic [3:0] M_PE    = 4'd12;
  localparam logic [3:0] M_PG    = 4'd13;

  // write-back actions, applied in the cycle after the multiply
  localparam logic [3:0] P_NONE     = 4'd0;
  localparam logic [3:0] P_SUM_BIAS = 4'd1;
  localparam logic [3:0] P_SUM_ZERO = 4'd2;
  localparam logic [3:0] P_SUM_ADD  = 4'd3;
  localparam logic [3:0] P_HP       = 4'd4;
  localparam logic [3:0] P_ACT_H    = 4'd5;
  localparam logic [3:0] P_YP       = 4'd6;
  localparam logic [3:0] P_ACT_Y    = 4'd7;
  localparam logic [3:0] P_ERR      = 4'd8;
  localparam logic [3:0] P_G        = 4'd9;
  localparam logic [3:0] P_ACC16    = 4'd10;
  localparam logic [3:0] P_ACCE     = 4'd11;
  localparam logic [3:0] P_UHI      = 4'd12;
  localparam logic [3:0] P_ULO      = 4'd13;

  typedef struct packed {
    logic [3:0]       mul;
    logic [3:0]       post;
    logic [WIX_W-1:0] widx;
    logic [SEL_W-1:0] n;
    logic [SEL_W-1:0] m;
    logic             load_in;
    logic             load_out;
    logic             applied;
  } dp_cmd_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 66'sd2147483647)        r = 32'sh7fff_ffff;
    else if (v < -66'sd2147483648)  r = 32'sh8000_0000;
    else                            r = v[DATA_W-1:0];
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > 66'sd140737488355327)        r = {1'b0, {(ACC_W-1){1'b1}}};
    else if (v < -66'sd140737488355328)  r = {1'b1, {(ACC_W-1){1'b0}}};
    else                                 r = v[ACC_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/mlp_sgd_trainer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlp_sgd_trainer
// 4-2-2 leaky-ReLU perceptron in Q16.16 with batched gradient descent.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result. A train request that
// closes a batch also runs the weight update (two multiplies per weight).
// The single shared 33x33 multiplier serves the forward, backward, gradient
// and update passes, at most one product per cycle. A finished result waits
// in the output register while the next request is accepted.
module mlp_sgd_trainer
  import mlpsgd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // weight_index, weight_value, sample_x0..x3, target0, target1, zero pad
  input  wire logic [231:0]  s_tdata,
  // req_type
  input  wire logic [1:0]    s_tuser,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // predict0, predict1, weight_read, batch_applied, zero pad
  output logic [103:0]       m_tdata,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);

  dp_cmd_t                  cmd;
  logic signed [DATA_W-1:0] predict0;
  logic signed [DATA_W-1:0] predict1;
  logic signed [DATA_W-1:0] weight_read;
  logic                     batch_applied;

  mlpsgd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .req_type  (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd)
  );

  mlpsgd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .req_type      (s_tuser),
    .weight_index  (s_tdata[3:0]),
    .weight_value  (s_tdata[35:4]),
    .sample_x0     (s_tdata[67:36]),
    .sample_x1     (s_tdata[99:68]),
    .sample_x2     (s_tdata[131:100]),
    .sample_x3     (s_tdata[163:132]),
    .target0       (s_tdata[195:164]),
    .target1       (s_tdata[227:196]),
    .predict0      (predict0),
    .predict1      (predict1),
    .weight_read   (weight_read),
    .batch_applied (batch_applied)
  );

  assign m_tdata = {7'b0, batch_applied, weight_read, predict1, predict0};

endmodule
`default_nettype wire

### rtl/mlpsgd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsgd_ctrl
// Sequencer: walks forward, error, backprop, gradient and update passes and
// issues one datapath command per cycle. Holds batch size and sample count.
// ----------------------------------------------------------------------------
module mlpsgd_ctrl
  import mlpsgd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [31:0]      cfg_data,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [1:0]       req_type,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output dp_cmd_t               cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FWDH = 4'd1;
  localparam logic [3:0] ST_FWDO = 4'd2;
  localparam logic [3:0] ST_WAIT = 4'd3;
  localparam logic [3:0] ST_ERR  = 4'd4;
  localparam logic [3:0] ST_BACK = 4'd5;
  localparam logic [3:0] ST_GRDO = 4'd6;
  localparam logic [3:0] ST_GRDH = 4'd7;
  localparam logic [3:0] ST_UPD  = 4'd8;
  localparam logic [3:0] ST_LAST = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0]       state;
  logic [CTR_W-1:0] j;
  logic [CTR_W-1:0] c;
  logic             is_train;
  logic             applied;
  logic             out_valid;
  logic [CNT_W-1:0] sample_count;
  logic [BS_W-1:0]  batch_len;
  logic [BS_W-1:0]  bs;
  logic [BS_W-1:0]  cnt_inc;
  logic             in_fire;
  logic             out_load;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = (state == ST_OUT) && (!out_valid || m_tready);

  always_comb begin
    if (batch_len == '0)            bs = BS_W'(1);
    else if (batch_len > BATCH_MAX) bs = BATCH_MAX;
    else                            bs = batch_len;
    cnt_inc = {1'b0, sample_count} + BS_W'(1);
  end

  always_comb begin
    cmd          = '0;
    cmd.load_in  = in_fire;
    cmd.load_out = out_load;
    cmd.applied  = applied;
    case (state)
      ST_FWDH: begin
        if (c == '0) begin
          cmd.post = P_SUM_BIAS;
          cmd.widx = WIX_W'(OFS_B1 + int'(j));
        end else if (c <= CTR_W'(NUM_INPUTS)) begin
          cmd.mul  = M_WX;
          cmd.post = P_SUM_ADD;
          cmd.widx = WIX_W'(OFS_W1 + int'(j) * NUM_INPUTS + int'(c) - 1);
          cmd.n    = SEL_W'(c - CTR_W'(1));
        end else if (c == CTR_W'(NUM_INPUTS + 1)) begin
          cmd.post = P_HP;
          cmd.n    = SEL_W'(j);
        end else if (c == CTR_W'(NUM_INPUTS + 3)) begin
          cmd.mul  = M_ACT_H;
          cmd.post = P_ACT_H;
          cmd.n    = SEL_W'(j);
        end
      end
      ST_FWDO: begin
        if (c == '0) begin
          cmd.post = P_SUM_BIAS;
          cmd.widx = WIX_W'(OFS_B2 + int'(j));
        end else if (c <= CTR_W'(NUM_HIDDEN)) begin
          cmd.mul  = M_WH;
          cmd.post = P_SUM_ADD;
          cmd.widx = WIX_W'(OFS_W2 + int'(j) * NUM_HIDDEN + int'(c) - 1);
          cmd.n    = SEL_W'(c - CTR_W'(1));
        end else if (c == CTR_W'(NUM_HIDDEN + 1)) begin
          cmd.post = P_YP;
          cmd.n    = SEL_W'(j);
        end else if (c == CTR_W'(NUM_HIDDEN + 3)) begin
          cmd.mul  = M_ACT_Y;
          cmd.post = P_ACT_Y;
          cmd.n    = SEL_W'(j);
        end
      end
      ST_ERR: begin
        cmd.mul  = M_ERR;
        cmd.post = P_ERR;
        cmd.n    = SEL_W'(j);
      end
      ST_BACK: begin
        if (c == '0) begin
          cmd.post = P_SUM_ZERO;
        end else if (c <= CTR_W'(NUM_OUTPUTS)) begin
          cmd.mul  = M_WE;
          cmd.post = P_SUM_ADD;
          cmd.widx = WIX_W'(OFS_W2 + (int'(c) - 1) * NUM_HIDDEN + int'(j));
          cmd.m    = SEL_W'(c - CTR_W'(1));
        end else if (c == CTR_W'(NUM_OUTPUTS + 2)) begin
          cmd.mul  = M_BACKD;
          cmd.post = P_G;
          cmd.n    = SEL_W'(j);
        end
      end
      ST_GRDO: begin
        if (c < CTR_W'(NUM_HIDDEN)) begin
          cmd.mul  = M_EH;
          cmd.post = P_ACC16;
          cmd.widx = WIX_W'(OFS_W2 + int'(j) * NUM_HIDDEN + int'(c));
          cmd.n    = SEL_W'(c);
          cmd.m    = SEL_W'(j);
        end else begin
          cmd.mul  = M_PE;
          cmd.post = P_ACCE;
          cmd.widx = WIX_W'(OFS_B2 + int'(j));
          cmd.m    = SEL_W'(j);
        end
      end
      ST_GRDH: begin
        if (c < CTR_W'(NUM_INPUTS)) begin
          cmd.mul  = M_GX;
          cmd.post = P_ACC16;
          cmd.widx = WIX_W'(OFS_W1 + int'(j) * NUM_INPUTS + int'(c));
          cmd.n    = SEL_W'(c);
          cmd.m    = SEL_W'(j);
        end else begin
          cmd.mul  = M_PG;
          cmd.post = P_ACCE;
          cmd.widx = WIX_W'(OFS_B1 + int'(j));
          cmd.m    = SEL_W'(j);
        end
      end
      ST_UPD: begin
        cmd.widx = WIX_W'(j);
        if (c == '0) begin
          cmd.mul  = M_UHI;
          cmd.post = P_UHI;
        end else begin
          cmd.mul  = M_ULO;
          cmd.post = P_ULO;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      j            <= '0;
      c            <= '0;
      is_train     <= 1'b0;
      applied      <= 1'b0;
      out_valid    <= 1'b0;
      sample_count <= '0;
      batch_len    <= BATCH_RST;
    end else begin
      if (cfg_we && cfg_index == CFG_BATCH) batch_len <= cfg_data[BS_W-1:0];

      if (out_load)                   out_valid <= 1'b1;
      else if (out_valid && m_tready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            is_train <= (req_type == REQ_TRAIN);
            applied  <= 1'b0;
            j        <= '0;
            c        <= '0;
            if (req_type == REQ_INFER || req_type == REQ_TRAIN) state <= ST_FWDH;
            else                                                 state <= ST_OUT;
          end
        end
        ST_FWDH: begin
          if (c == CTR_W'(NUM_INPUTS + 3)) begin
            c <= '0;
            if (j == CTR_W'(NUM_HIDDEN - 1)) begin
              j     <= '0;
              state <= ST_FWDO;
            end else begin
              j <= j + CTR_W'(1);
            end
          end else begin
            c <= c + CTR_W'(1);
          end
        end
        ST_FWDO: begin
          if (c == CTR_W'(NUM_HIDDEN + 3)) begin
            c <= '0;
            if (j == CTR_W'(NUM_OUTPUTS - 1)) begin
              j     <= '0;
              state <= ST_WAIT;
            end else begin
              j <= j + CTR_W'(1);
            end
          end else begin
            c <= c + CTR_W'(1);
          end
        end
        ST_WAIT: begin
          state <= is_train ? ST_ERR : ST_OUT;
        end
        ST_ERR: begin
          if (j == CTR_W'(NUM_OUTPUTS - 1)) begin
            j     <= '0;
            c     <= '0;
            state <= ST_BACK;
          end else begin
            j <= j + CTR_W'(1);
          end
        end
        ST_BACK: begin
          if (c == CTR_W'(NUM_OUTPUTS + 2)) begin
            c <= '0;
            if (j == CTR_W'(NUM_HIDDEN - 1)) begin
              j     <= '0;
              state <= ST_GRDO;
            end else begin
              j <= j + CTR_W'(1);
            end
          end else begin
            c <= c + CTR_W'(1);
          end
        end
        ST_GRDO: begin
          if (c == CTR_W'(NUM_HIDDEN)) begin
            c <= '0;
            if (j == CTR_W'(NUM_OUTPUTS - 1)) begin
              j     <= '0;
              state <= ST_GRDH;
            end else begin
              j <= j + CTR_W'(1);
            end
          end else begin
            c <= c + CTR_W'(1);
          end
        end
        ST_GRDH: begin
          if (c == CTR_W'(NUM_INPUTS)) begin
            c <= '0;
            if (j == CTR_W'(NUM_HIDDEN - 1)) begin
              j <= '0;
              if (cnt_inc >= bs) begin
                sample_count <= '0;
                applied      <= 1'b1;
                state        <= ST_UPD;
              end else begin
                sample_count <= cnt_inc[CNT_W-1:0];
                state        <= ST_OUT;
              end
            end else begin
              j <= j + CTR_W'(1);
            end
          end else begin
            c <= c + CTR_W'(1);
          end
        end
        ST_UPD: begin
          if (c == '0) begin
            c <= CTR_W'(1);
          end else begin
            c <= '0;
            if (j == CTR_W'(NUM_WEIGHTS - 1)) begin
              j     <= '0;
              state <= ST_LAST;
            end else begin
              j <= j + CTR_W'(1);
            end
          end
        end
        ST_LAST: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/mlpsgd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsgd_dp
// Datapath: weight and gradient registers, one shared 33x33 multiplier and a
// write-back stage that adds, saturates and applies activations.
// ----------------------------------------------------------------------------
module mlpsgd_dp
  import mlpsgd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [31:0]               cfg_data,
  input  wire dp_cmd_t                   cmd,
  input  wire logic [1:0]                req_type,
  input  wire logic [3:0]                weight_index,
  input  wire logic signed [DATA_W-1:0]  weight_value,
  input  wire logic signed [DATA_W-1:0]  sample_x0,
  input  wire logic signed [DATA_W-1:0]  sample_x1,
  input  wire logic signed [DATA_W-1:0]  sample_x2,
  input  wire logic signed [DATA_W-1:0]  sample_x3,
  input  wire logic signed [DATA_W-1:0]  target0,
  input  wire logic signed [DATA_W-1:0]  target1,
  output logic signed [DATA_W-1:0]       predict0,
  output logic signed [DATA_W-1:0]       predict1,
  output logic signed [DATA_W-1:0]       weight_read,
  output logic                           batch_applied
);

  logic signed [DATA_W-1:0] w   [NUM_WEIGHTS];
  logic signed [ACC_W-1:0]  acc [NUM_WEIGHTS];
  logic signed [DATA_W-1:0] x   [NUM_INPUTS];
  logic signed [DATA_W-1:0] t   [NUM_OUTPUTS];
  logic signed [DATA_W-1:0] hp  [NUM_HIDDEN];
  logic signed [DATA_W-1:0] h   [NUM_HIDDEN];
  logic signed [DATA_W-1:0] g   [NUM_HIDDEN];
  logic signed [DATA_W-1:0] yp  [NUM_OUTPUTS];
  logic signed [DATA_W-1:0] y   [NUM_OUTPUTS];
  logic signed [DATA_W-1:0] e   [NUM_OUTPUTS];
  logic signed [DATA_W-1:0] xin [4];
  logic signed [DATA_W-1:0] tin [2];

  logic [31:0]              step_scale;
  logic [23:0]              leak_slope;
  logic [1:0]               req_q;
  logic [3:0]               idx_q;

  dp_cmd_t                  cq;
  logic signed [PROD_W-1:0] prod;
  logic signed [OPR_W-1:0]  aq;
  logic signed [DATA_W-1:0] wq;
  logic signed [ACC_W-1:0]  accq;
  logic signed [SUM_W-1:0]  sum;
  logic signed [USUM_W-1:0] usum;

  logic [WIX_W-1:0]         raddr;
  logic signed [DATA_W-1:0] wsel;
  logic signed [ACC_W-1:0]  accsel;
  logic signed [OPR_W-1:0]  opa;
  logic signed [OPR_W-1:0]  opb;
  logic signed [UPD_W-1:0]  upd;
  logic signed [UPD_W-1:0]  wdiff;
  logic signed [ACC_W-1:0]  acc_new;
  logic                     in_write;
  logic [OI_W-1:0]          out1;

  function automatic logic signed [OPR_W-1:0] deriv(input logic signed [DATA_W-1:0] p,
                                                    input logic [23:0] leak);
    logic [24:0] d;
    d = (p > 0) ? ONE_Q24 : {1'b0, leak};
    return $signed({8'b0, d});
  endfunction

  assign xin[0] = sample_x0;
  assign xin[1] = sample_x1;
  assign xin[2] = sample_x2;
  assign xin[3] = sample_x3;
  assign tin[0] = target0;
  assign tin[1] = target1;

  assign in_write = cmd.load_in && (req_type == REQ_WRITE) && (int'(weight_index) < NUM_WEIGHTS);
  assign raddr    = cmd.load_out ? WIX_W'(idx_q) : cmd.widx;
  assign wsel     = w[raddr];
  assign accsel   = acc[cmd.widx];
  assign out1     = OI_W'((NUM_OUTPUTS > 1) ? 1 : 0);

  // operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.mul)
      M_WX: begin
        opa = OPR_W'(wsel);
        opb = OPR_W'(x[cmd.n[XI_W-1:0]]);
      end
      M_WH: begin
        opa = OPR_W'(wsel);
        opb = OPR_W'(h[cmd.n[HI_W-1:0]]);
      end
      M_ACT_H: begin
        opa = OPR_W'(hp[cmd.n[HI_W-1:0]]);
        opb = $signed({9'b0, leak_slope});
      end
      M_ACT_Y: begin
        opa = OPR_W'(yp[cmd.n[OI_W-1:0]]);
        opb = $signed({9'b0, leak_slope});
      end
      M_ERR: begin
        opa = OPR_W'(y[cmd.n[OI_W-1:0]]) - OPR_W'(t[cmd.n[OI_W-1:0]]);
        opb = deriv(yp[cmd.n[OI_W-1:0]], leak_slope);
      end
      M_WE: begin
        opa = OPR_W'(wsel);
        opb = OPR_W'(e[cmd.m[OI_W-1:0]]);
      end
      M_BACKD: begin
        opa = OPR_W'(sat32(PROD_W'(sum)));
        opb = deriv(hp[cmd.n[HI_W-1:0]], leak_slope);
      end
      M_EH: begin
        opa = OPR_W'(e[cmd.m[OI_W-1:0]]);
        opb = OPR_W'(h[cmd.n[HI_W-1:0]]);
      end
      M_GX: begin
        opa = OPR_W'(g[cmd.m[HI_W-1:0]]);
        opb = OPR_W'(x[cmd.n[XI_W-1:0]]);
      end
      M_UHI: begin
        opa = OPR_W'($signed(accsel[ACC_W-1:24]));
        opb = $signed({1'b0, step_scale});
      end
      M_ULO: begin
        opa = $signed({9'b0, accsel[23:0]});
        opb = $signed({1'b0, step_scale});
      end
      M_PE: begin
        opa = OPR_W'(e[cmd.m[OI_W-1:0]]);
      end
      M_PG: begin
        opa = OPR_W'(g[cmd.m[HI_W-1:0]]);
      end
      default: begin
      end
    endcase
  end

  // write-back arithmetic
  always_comb begin
    upd     = (UPD_W'(usum) <<< 24) + UPD_W'(prod);
    wdiff   = UPD_W'(wq) - (upd >>> 32);
    acc_new = '0;
    case (cq.post)
      P_ACC16: acc_new = sat48(PROD_W'(accq) + (prod >>> 16));
      P_ACCE:  acc_new = sat48(PROD_W'(accq) + PROD_W'(aq));
      default: acc_new = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cq         <= '0;
      step_scale <= STEP_RST;
      leak_slope <= LEAK_RST;
    end else begin
      cq <= cmd;
      if (cfg_we && cfg_index == CFG_STEP) step_scale <= cfg_data;
      if (cfg_we && cfg_index == CFG_LEAK) leak_slope <= cfg_data[23:0];
    end
  end

  // weight and gradient state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        w[i]   <= '0;
        acc[i] <= '0;
      end
    end else if (in_write) begin
      w[WIX_W'(weight_index)] <= weight_value;
    end else begin
      case (cq.post)
        P_ACC16, P_ACCE: acc[cq.widx] <= acc_new;
        P_ULO: begin
          w[cq.widx]   <= sat32(PROD_W'(wdiff));
          acc[cq.widx] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline and working registers
  always_ff @(posedge clk) begin
    prod <= opa * opb;
    aq   <= opa;
    wq   <= wsel;
    accq <= accsel;

    if (cmd.load_in) begin
      req_q <= req_type;
      idx_q <= weight_index;
      for (int i = 0; i < NUM_INPUTS; i++) x[i] <= (i < 4) ? xin[i[1:0]] : '0;
      for (int k = 0; k < NUM_OUTPUTS; k++) t[k] <= (k < 2) ? tin[k[0]] : '0;
    end

    case (cq.post)
      P_SUM_BIAS: sum <= SUM_W'(wq);
      P_SUM_ZERO: sum <= '0;
      P_SUM_ADD:  sum <= sum + SUM_W'(prod >>> 16);
      P_HP:       hp[cq.n[HI_W-1:0]] <= sat32(PROD_W'(sum));
      P_ACT_H:    h[cq.n[HI_W-1:0]]  <= (aq > 0) ? aq[DATA_W-1:0] : DATA_W'(prod >>> 24);
      P_YP:       yp[cq.n[OI_W-1:0]] <= sat32(PROD_W'(sum));
      P_ACT_Y:    y[cq.n[OI_W-1:0]]  <= (aq > 0) ? aq[DATA_W-1:0] : DATA_W'(prod >>> 24);
      P_ERR:      e[cq.n[OI_W-1:0]]  <= sat32(prod >>> 24);
      P_G:        g[cq.n[HI_W-1:0]]  <= sat32(prod >>> 24);
      P_UHI:      usum <= $signed(prod[USUM_W-1:0]);
      default: begin
      end
    endcase

    if (cmd.load_out) begin
      if (req_q == REQ_INFER || req_q == REQ_TRAIN) begin
        predict0 <= y[0];
        predict1 <= (NUM_OUTPUTS > 1) ? y[out1] : '0;
      end else begin
        predict0 <= '0;
        predict1 <= '0;
      end
      weight_read   <= (req_q == REQ_READ && int'(idx_q) < NUM_WEIGHTS) ? wsel : '0;
      batch_applied <= cmd.applied;
    end
  end

endmodule
`default_nettype wire

### verif/mlp_sgd_trainer_tb.sv
// ----------------------------------------------------------------------------
// mlp_sgd_trainer_tb
// Self-checking bench for the 4-2-2 perceptron trainer: weight writes and
// reads, inference and batched training requests are predicted in Q16.16 and
// every result is compared field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module mlp_sgd_trainer_tb;
  import mlpsgd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         kind;
    logic [3:0]         widx;
    logic signed [31:0] wval;
    logic signed [31:0] x [4];
    logic signed [31:0] t [2];
  } net_req_t;

  typedef struct packed {
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] rd;
    logic               applied;
  } net_rsp_t;

  typedef struct {
    net_req_t req;
    bit       has_exp;
    net_rsp_t exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [231:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  mlp_sgd_trainer u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [6:0]         mdl_batch;
  logic [31:0]        mdl_step;
  logic [23:0]        mdl_leak;
  longint             mdl_w [16];
  longint             mdl_acc [16];
  int                 mdl_count;

  net_rsp_t           pending_rsp [$];
  int                 errors = 0;
  longint             cycles = 0;
  bit                 hold_long = 1'b0;
  bit                 stim_done = 1'b0;

  function automatic longint fl(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint leaky(longint p);
    return p > 0 ? p : fl(p * longint'(mdl_leak), 24);
  endfunction

  function automatic longint slope(longint p);
    return p > 0 ? 64'sd16777216 : longint'(mdl_leak);
  endfunction

  function automatic void accum(int i, longint g);
    longint s;
    s = mdl_acc[i] + g;
    if (s > 64'sd140737488355327) s = 64'sd140737488355327;
    if (s < -64'sd140737488355328) s = -64'sd140737488355328;
    mdl_acc[i] = s;
  endfunction

  // floor(a * s / 2^32) done in 128 bits
  function automatic longint scaled_step(longint a, logic [31:0] s);
    logic signed [127:0] p;
    p = 128'(signed'(a)) * $signed({96'd0, s});
    return longint'(p >>> 32);
  endfunction

  function automatic net_rsp_t run_net(net_req_t r);
    net_rsp_t o;
    longint hp [2], h [2], yp [2], y [2], e [2], g [2], s;
    int bs;
    o = '{0, 0, 0, 0};
    if (r.kind == REQ_WRITE) begin
      mdl_w[r.widx] = longint'(r.wval);
      return o;
    end
    if (r.kind == REQ_READ) begin
      o.rd = 32'(mdl_w[r.widx]);
      return o;
    end
    for (int j = 0; j < 2; j++) begin
      s = mdl_w[OFS_B1 + j];
      for (int i = 0; i < 4; i++) s += fl(mdl_w[j*4 + i] * longint'(r.x[i]), 16);
      hp[j] = clip32(s);
      h[j] = leaky(hp[j]);
    end
    for (int k = 0; k < 2; k++) begin
      s = mdl_w[OFS_B2 + k];
      for (int j = 0; j < 2; j++) s += fl(mdl_w[OFS_W2 + k*2 + j] * h[j], 16);
      yp[k] = clip32(s);
      y[k] = leaky(yp[k]);
    end
    o.p0 = 32'(y[0]);
    o.p1 = 32'(y[1]);
    if (r.kind != REQ_TRAIN) return o;
    bs = mdl_batch == 0 ? 1 : (mdl_batch > 64 ? 64 : int'(mdl_batch));
    for (int k = 0; k < 2; k++)
      e[k] = clip32(fl((y[k] - longint'(r.t[k])) * slope(yp[k]), 24));
    for (int j = 0; j < 2; j++) begin
      s = 0;
      for (int k = 0; k < 2; k++) s += fl(mdl_w[OFS_W2 + k*2 + j] * e[k], 16);
      g[j] = clip32(fl(clip32(s) * slope(hp[j]), 24));
    end
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 2; j++) accum(OFS_W2 + k*2 + j, fl(e[k] * h[j], 16));
      accum(OFS_B2 + k, e[k]);
    end
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 4; i++) accum(j*4 + i, fl(g[j] * longint'(r.x[i]), 16));
      accum(OFS_B1 + j, g[j]);
    end
    mdl_count = (mdl_count + 1) & 8'h7f;
    if (mdl_count >= bs) begin
      for (int i = 0; i < 16; i++) begin
        mdl_w[i] = clip32(mdl_w[i] - scaled_step(mdl_acc[i], mdl_step));
        mdl_acc[i] = 0;
      end
      mdl_count = 0;
      o.applied = 1'b1;
    end
    return o;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // tvalid stays up after an accept unless the next request waits first
  task automatic send_req(net_req_t r, bit has_exp = 0, net_rsp_t fixed = '{0, 0, 0, 0});
    net_rsp_t e;
    int gap;
    gap = $urandom_range(0, 6) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      idle_cycles(gap);
    end
    e = run_net(r);
    if (has_exp && e != fixed) begin
      $display("%0t predictor disagrees on table row: exp %p got %p", $realtime, fixed, e);
      errors++;
    end
    pending_rsp.push_back(e);
    s_tvalid <= 1'b1;
    s_tuser <= r.kind;
    s_tdata <= {4'b0, r.t[1], r.t[0], r.x[3], r.x[2], r.x[1], r.x[0], r.wval, r.widx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    idle_cycles(120);
  endtask

  // write enable is dropped by the caller after the last write
  task automatic set_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_BATCH: mdl_batch = val[6:0];
      CFG_STEP:  mdl_step = val;
      CFG_LEAK:  mdl_leak = val[23:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return signed'(32'($urandom_range(0, 32'h4_0000))) - 32'sh2_0000;
    endcase
  endfunction

  function automatic net_req_t rand_req(int mix);
    net_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.widx = 4'($urandom_range(0, 15));
    r.wval = (pick < mix) ? rand_q() : signed'(32'($urandom_range(0, 32'h2_0000))) - 32'sh1_0000;
    for (int i = 0; i < 4; i++) r.x[i] = rand_q();
    for (int k = 0; k < 2; k++) r.t[k] = rand_q();
    if (pick < 15) r.kind = REQ_WRITE;
    else if (pick < 22) r.kind = REQ_READ;
    else if (pick < 35) r.kind = REQ_INFER;
    else r.kind = REQ_TRAIN;
    return r;
  endfunction

  // receiver
  initial begin
    int gap;
    net_rsp_t got, want;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        m_tready <= 1'b0;
        while (hold_long) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        m_tready <= 1'b0;
        idle_cycles(gap);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.p0 = m_tdata[31:0];
      got.p1 = m_tdata[63:32];
      got.rd = m_tdata[95:64];
      got.applied = m_tdata[96];
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result: got %p", $realtime, got);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.p0 !== want.p0) begin
          $display("%0t predict0: exp %h got %h", $realtime, want.p0, got.p0); errors++;
        end
        if (got.p1 !== want.p1) begin
          $display("%0t predict1: exp %h got %h", $realtime, want.p1, got.p1); errors++;
        end
        if (got.rd !== want.rd) begin
          $display("%0t weight_read: exp %h got %h", $realtime, want.rd, got.rd); errors++;
        end
        if (got.applied !== want.applied) begin
          $display("%0t batch_applied: exp %b got %b", $realtime, want.applied,
                   got.applied); errors++;
        end
        if (m_tdata[103:97] !== '0) begin
          $display("%0t pad: exp 0 got %h", $realtime, m_tdata[103:97]); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd1_500_000) begin
      $display("mlp_sgd_trainer regression: fail");
      $finish;
    end
  end

  function automatic net_req_t mk(logic [1:0] k, logic [3:0] i, logic signed [31:0] v,
                                  logic signed [31:0] xa, logic signed [31:0] tt);
    net_req_t r;
    r.kind = k; r.widx = i; r.wval = v;
    for (int n = 0; n < 4; n++) r.x[n] = xa;
    r.t[0] = tt; r.t[1] = -tt;
    return r;
  endfunction

  initial begin
    stim_row_t dir [$];
    net_req_t r;
    int n;
    logic [31:0] steps [4];
    logic [31:0] leaks [3];
    logic [6:0]  batches [5];
    mdl_batch = BATCH_RST; mdl_step = STEP_RST; mdl_leak = LEAK_RST;
    for (int i = 0; i < 16; i++) begin mdl_w[i] = 0; mdl_acc[i] = 0; end
    mdl_count = 0;
    idle_cycles(4);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: read after reset, extremes, all kinds
    dir.push_back('{mk(REQ_READ, 4'd0, 0, 0, 0), 1, '{0, 0, 0, 0}});
    dir.push_back('{mk(REQ_INFER, 4'd0, 0, 32'sh7fff_ffff, 0), 1, '{0, 0, 0, 0}});
    dir.push_back('{mk(REQ_WRITE, 4'd15, 32'sh7fff_ffff, 32'sh8000_0000, 0), 1, '{0,0,0,0}});
    dir.push_back('{mk(REQ_READ, 4'd15, 0, 0, 0), 1, '{0, 0, 32'sh7fff_ffff, 0}});
    dir.push_back('{mk(REQ_WRITE, 4'd14, 32'sh8000_0000, 0, 0), 1, '{0, 0, 0, 0}});
    dir.push_back('{mk(REQ_READ, 4'd14, 0, 0, 0), 1, '{0, 0, 32'sh8000_0000, 0}});
    // most negative bias through the default leak: -2^31 * 1678 / 2^24
    dir.push_back('{mk(REQ_INFER, 4'd3, 0, 0, 0), 1,
                    '{-32'sd214784, 32'sh7fff_ffff, 0, 0}});
    for (int i = 0; i < 14; i++)
      dir.push_back('{mk(REQ_WRITE, 4'(i), 32'sh1_0000 - i*32'sh3000, 0, 0), 0, '{0,0,0,0}});
    dir.push_back('{mk(REQ_INFER, 4'd0, 0, 32'sh7fff_ffff, 0), 0, '{0, 0, 0, 0}});
    dir.push_back('{mk(REQ_TRAIN, 4'd0, 0, 32'sh8000_0000, 32'sh7fff_ffff), 0, '{0,0,0,0}});
    dir.push_back('{mk(REQ_TRAIN, 4'd0, 0, 32'sh1_0000, 32'sh8000_0000), 0, '{0,0,0,0}});
    foreach (dir[i]) send_req(dir[i].req, dir[i].has_exp, dir[i].exp);
    wait_drain();

    // short batches with default settings, to complete a batch before reconfiguring
    for (int i = 0; i < 12; i++) begin
      r = rand_req(20); r.kind = REQ_TRAIN; send_req(r);
    end
    wait_drain();

    steps = '{32'd0, 32'hffff_ffff, 32'd429497, 32'h0100_0000};
    leaks = '{32'd0, 32'h00ff_ffff, 32'd1678};
    batches = '{7'd0, 7'd1, 7'd127, 7'd64, 7'd3};
    n = 0;
    for (int ph = 0; ph < 10; ph++) begin
      set_reg(CFG_BATCH, 32'(batches[ph % 5]));
      set_reg(CFG_STEP, steps[ph % 4]);
      set_reg(CFG_LEAK, leaks[ph % 3]);
      cfg_we <= 1'b0;
      if (ph == 4) begin
        // long receiver hold while requests keep coming
        fork
          begin hold_long = 1'b1; idle_cycles(600); hold_long = 1'b0; end
          for (int i = 0; i < 8; i++) begin r = rand_req(30); send_req(r); end
        join
      end
      for (int i = 0; i < 185; i++) begin
        r = rand_req(ph % 3 == 0 ? 60 : 10);
        send_req(r);
        n++;
      end
      wait_drain();
    end
    stim_done = 1'b1;

    if (errors == 0) begin
      $display("mlp_sgd_trainer regression: pass");
    end else begin
      $display("mlp_sgd_trainer regression: fail");
    end
    $finish;
  end

endmodule
